### rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies; imported by every module of the block.
`default_nettype none

package deq_pkg;

    // Ring store geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;

    // Command codes; codes 6 and 7 are ignored by the datapath
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } cmd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // take the input word and execute it
    } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/deq_ctrl.sv
// Handshake controller of the double-ended queue core.
// Depends on deq_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module deq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output deq_pkg::dp_cmd_t      dp_cmd
);
    import deq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   cmd_ready_reg;
    logic   rsp_valid_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg     <= ST_RESP;
                        cmd_ready_reg <= 1'b0;
                        rsp_valid_reg <= 1'b1;
                    end
                end
                ST_RESP:
                begin
                    if (rsp_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        cmd_ready_reg <= 1'b1;
                        rsp_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    cmd_ready_reg <= 1'b1;
                    rsp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign cmd_ready   = cmd_ready_reg;
    assign rsp_valid   = rsp_valid_reg;
    assign dp_cmd.load = cmd_valid && cmd_ready_reg;

endmodule

`default_nettype wire

### rtl/deq_datapath.sv
// Datapath of the double-ended queue core: ring store, indices, result regs.
// Depends on deq_pkg; sequenced by deq_ctrl through dp_cmd_t.
`default_nettype none

module deq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire deq_pkg::dp_cmd_t              dp_cmd,
    input  wire logic [deq_pkg::CMD_W-1:0]     command,
    input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic                               ok,
    output logic signed [deq_pkg::DATA_W-1:0]  read_value,
    output logic [deq_pkg::CNT_W-1:0]          element_count
);
    import deq_pkg::*;

    // Ring store
    logic [DATA_W-1:0] mem [DEPTH];

    // Control state
    logic [ADDR_W-1:0] front_reg;
    logic [ADDR_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Result registers
    logic              ok_reg;
    logic              ok_next;
    logic              is_read_reg;
    logic              is_read_next;
    logic [DATA_W-1:0] rd_data_reg;

    // Access decode
    logic              full;
    logic              empty;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] front_inc;
    logic [ADDR_W-1:0] front_dec;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  back_sum;
    logic [ADDR_W-1:0] tail_slot;
    logic [ADDR_W-1:0] back_slot;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Index arithmetic modulo DEPTH (the tail sum stays below twice DEPTH)
    assign front_inc = (front_reg == ADDR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_sum  = tail_sum - 1'b1;
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ?
                       ADDR_W'(tail_sum - SUM_W'(DEPTH)) : ADDR_W'(tail_sum);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ?
                       ADDR_W'(back_sum - SUM_W'(DEPTH)) : ADDR_W'(back_sum);

    // Command decode
    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        is_read_next = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = tail_slot;
        rd_addr      = front_reg;
        unique case (command)
            CMD_PUSH_FRONT:
            begin
                wr_addr = front_dec;
                if (!full)
                begin
                    wr_en      = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (!full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                is_read_next = 1'b1;
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                is_read_next = 1'b1;
                rd_addr      = back_slot;
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            CMD_PEEK_FRONT:
            begin
                is_read_next = 1'b1;
                if (!empty)
                begin
                    rd_en   = 1'b1;
                    ok_next = 1'b1;
                end
            end
            CMD_PEEK_BACK:
            begin
                is_read_next = 1'b1;
                rd_addr      = back_slot;
                if (!empty)
                begin
                    rd_en   = 1'b1;
                    ok_next = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave indices, count and store as is; ok reads low
            end
        endcase
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load && wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (dp_cmd.load && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Index, count and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
            is_read_reg <= 1'b0;
        end
        else if (dp_cmd.load)
        begin
            front_reg   <= front_next;
            count_reg   <= count_next;
            ok_reg      <= ok_next;
            is_read_reg <= is_read_next;
        end
    end

    assign ok            = ok_reg;
    assign read_value    = (ok_reg && is_read_reg) ? rd_data_reg : '0;
    assign element_count = count_reg;

endmodule

`default_nettype wire

### rtl/double_ended_queue_core.sv
// Double-ended queue core: 32-bit words in a DEPTH-entry ring store.
// Response: the result word is offered in the cycle after the command is accepted.
// Flow: the controller takes no new command while the single response word
// waits; a stall on the response side holds the next command.
// Reset: asynchronous active low; the queue comes up empty, store left unset.
`default_nettype none

module double_ended_queue_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic [deq_pkg::CMD_W-1:0]         command,
    input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic                                   ok,
    output logic signed [deq_pkg::DATA_W-1:0]      read_value,
    output logic [deq_pkg::CNT_W-1:0]              element_count
);
    import deq_pkg::*;

    dp_cmd_t dp_cmd;

    // Handshake sequencing
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_cmd    (dp_cmd)
    );

    // Store and index update
    deq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .command       (command),
        .push_value    (push_value),
        .ok            (ok),
        .read_value    (read_value),
        .element_count (element_count)
    );

`ifndef SYNTHESIS
    // An accepted command produces a response word in the next cycle
    a_cmd_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (rsp_valid && !cmd_ready))
        else $error("no response after accepted command");

    // A delivered response frees the command side
    a_rsp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |=> (cmd_ready && !rsp_valid))
        else $error("controller did not return to idle");

    // A push succeeds exactly when not full, and then grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready &&
         (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK)) |=>
        ((ok == ($past(element_count) != CNT_W'(DEPTH))) &&
         (element_count == (ok ? $past(element_count) + 1'b1 : $past(element_count)))))
        else $error("push count update mismatch");

    // A pop succeeds exactly when not empty, and then shrinks the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready &&
         (command == CMD_POP_FRONT || command == CMD_POP_BACK)) |=>
        ((ok == ($past(element_count) != '0)) &&
         (element_count == (ok ? $past(element_count) - 1'b1 : $past(element_count)))))
        else $error("pop count update mismatch");
`endif

endmodule

`default_nettype wire
